### rtl/core/sctc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctc_pkg
// Shared types and character codes for the scrolling text console.
// ----------------------------------------------------------------------------
package sctc_pkg;

  localparam int CHAR_W  = 8;
  localparam int FIELD_W = 5;

  localparam logic [CHAR_W-1:0] CODE_BS        = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_NL        = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_PRINT_MIN = 8'h20;
  localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CODE_ZERO      = 8'h00;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } sctc_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BLANK,
    ST_DONE
  } sctc_state_t;

  // control strobes towards the text store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } sctc_mem_ctl_t;

endpackage

### rtl/core/sctc_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctc_mem
// Text store: one port with a shared address, for writes and for registered reads.
// ----------------------------------------------------------------------------
module sctc_mem #(
  parameter int DEPTH = 600,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  sctc_pkg::sctc_mem_ctl_t    ctl,
  input  logic [AW-1:0]              addr,
  input  logic [sctc_pkg::CHAR_W-1:0] wdata,
  output logic [sctc_pkg::CHAR_W-1:0] rdata
);
  import sctc_pkg::*;

  logic [CHAR_W-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      store[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= store[addr];
    end
  end

endmodule

### rtl/core/sctc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctc_ctrl
// Cursor, sequencer and result register for the scrolling text console.
// ----------------------------------------------------------------------------
module sctc_ctrl #(
  parameter int ROWS = 20,
  parameter int COLS = 30,
  parameter int AW   = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [sctc_pkg::CHAR_W-1:0]   char_code,
  input  logic [sctc_pkg::FIELD_W-1:0]  screen_row,
  input  logic [sctc_pkg::FIELD_W-1:0]  screen_col,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sctc_pkg::CHAR_W-1:0]   cell_value,
  output logic [sctc_pkg::FIELD_W-1:0]  cursor_row,
  output logic [sctc_pkg::FIELD_W-1:0]  cursor_col,
  output logic [sctc_pkg::FIELD_W-1:0]  top_row,
  output sctc_pkg::sctc_mem_ctl_t       mem_ctl,
  output logic [AW-1:0]                 mem_addr,
  output logic [sctc_pkg::CHAR_W-1:0]   mem_wdata,
  input  logic [sctc_pkg::CHAR_W-1:0]   mem_rdata
);
  import sctc_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int SW    = ((RW > FIELD_W) ? RW : FIELD_W) + 1;
  localparam int DEPTH = ROWS * COLS;

  sctc_state_t   state, state_next;
  logic [RW-1:0] cur_row, cur_row_next;
  logic [CW-1:0] cur_col, cur_col_next;
  logic [CW-1:0] bcol, bcol_next;
  logic [AW-1:0] clr_cnt, clr_cnt_next;
  logic          pend_read, pend_read_next;
  logic          out_valid_next;
  logic          load;

  logic [RW-1:0] row_inc, row_dec, rd_row;
  logic [SW-1:0] rd_sum;
  logic [AW-1:0] row_base, rd_addr;
  logic          in_range, accept, col_last;
  logic          is_print, is_nl, is_bs;

  assign row_inc  = (cur_row == RW'(ROWS - 1)) ? '0 : cur_row + RW'(1);
  assign row_dec  = (cur_row == '0) ? RW'(ROWS - 1) : cur_row - RW'(1);
  assign rd_sum   = SW'(row_inc) + SW'(screen_row);
  assign rd_row   = (rd_sum >= SW'(ROWS)) ? RW'(rd_sum - SW'(ROWS)) : RW'(rd_sum);
  assign row_base = AW'(cur_row * COLS);
  assign rd_addr  = AW'(rd_row * COLS) + AW'(screen_col);
  assign in_range = (int'(screen_row) < ROWS) && (int'(screen_col) < COLS);
  assign col_last = (cur_col == CW'(COLS - 1));
  assign is_print = (char_code >= CODE_PRINT_MIN);
  assign is_nl    = (char_code == CODE_NL);
  assign is_bs    = (char_code == CODE_BS);

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign load     = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next     = state;
    cur_row_next   = cur_row;
    cur_col_next   = cur_col;
    bcol_next      = bcol;
    clr_cnt_next   = clr_cnt;
    pend_read_next = pend_read;
    mem_ctl        = '{wr_en: 1'b0, rd_en: 1'b0};
    mem_addr       = row_base + AW'(cur_col);
    mem_wdata      = CODE_SPACE;
    unique case (state)
      ST_CLEAR: begin
        mem_ctl.wr_en = 1'b1;
        mem_addr      = clr_cnt;
        mem_wdata     = CODE_ZERO;
        clr_cnt_next  = clr_cnt + AW'(1);
        if (clr_cnt == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          pend_read_next = 1'b0;
          state_next     = ST_DONE;
          if (sctc_op_t'(op) == OP_READ) begin
            if (in_range) begin
              mem_ctl.rd_en  = 1'b1;
              mem_addr       = rd_addr;
              pend_read_next = 1'b1;
            end
          end else if (is_print) begin
            mem_ctl.wr_en = 1'b1;
            mem_wdata     = char_code;
            if (col_last) begin
              cur_row_next = row_inc;
              cur_col_next = '0;
              bcol_next    = '0;
              state_next   = ST_BLANK;
            end else begin
              cur_col_next = cur_col + CW'(1);
            end
          end else if (is_nl) begin
            cur_row_next = row_inc;
            cur_col_next = '0;
            bcol_next    = '0;
            state_next   = ST_BLANK;
          end else if (is_bs) begin
            mem_ctl.wr_en = 1'b1;
            if (cur_col == '0) begin
              cur_col_next = CW'(COLS - 1);
              cur_row_next = row_dec;
            end else begin
              cur_col_next = cur_col - CW'(1);
            end
          end
        end
      end
      ST_BLANK: begin
        mem_ctl.wr_en = 1'b1;
        mem_addr      = row_base + AW'(bcol);
        bcol_next     = bcol + CW'(1);
        if (bcol == CW'(COLS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_valid_next = load ? 1'b1 : (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row   <= '0;
      cur_col   <= '0;
      bcol      <= '0;
      clr_cnt   <= '0;
      pend_read <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cur_row   <= cur_row_next;
      cur_col   <= cur_col_next;
      bcol      <= bcol_next;
      clr_cnt   <= clr_cnt_next;
      pend_read <= pend_read_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cell_value <= pend_read ? mem_rdata : CODE_ZERO;
      cursor_row <= FIELD_W'(cur_row);
      cursor_col <= FIELD_W'(cur_col);
      top_row    <= FIELD_W'(row_inc);
    end
  end

`ifndef NO_ASSERTIONS
  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    (int'(cur_row) < ROWS) && (int'(cur_col) < COLS))
    else $error("cursor outside the screen");

  a_top_not_cursor: assert property (@(posedge clk) disable iff (rst)
    row_inc != cur_row)
    else $error("top row equals cursor row");

  a_single_port: assert property (@(posedge clk) disable iff (rst)
    !(mem_ctl.wr_en && mem_ctl.rd_en))
    else $error("store read and written in one cycle");

  a_blank_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BLANK) && (bcol == CW'(COLS - 1)) |=>
      (state == ST_DONE) && (cur_col == '0))
    else $error("row blanking ended badly");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid && (cursor_col == FIELD_W'($past(cur_col))))
    else $error("result not presented");
`endif

endmodule

### rtl/core/scrolling_text_console.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrolling_text_console
// Character console kept as a ring of rows with a cursor, held in one store.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_ready  op, char_code, screen_row, screen_col
//  out      out_valid / out_ready cell_value, cursor_row, cursor_col, top_row
//
//  A read or a character that stays on its row passes ST_IDLE and ST_DONE; a
//  newline or end of row passes ST_BLANK between them (one store write per
//  blanked cell). After reset the store is swept to zero before the first
//  beat is taken. A waiting result holds the next result back in ST_DONE;
//  the following beat is accepted, but later ones wait until that result goes.
// ----------------------------------------------------------------------------
module scrolling_text_console #(
  parameter int ROWS = 20,
  parameter int COLS = 30
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [sctc_pkg::CHAR_W-1:0]   char_code,
  input  logic [sctc_pkg::FIELD_W-1:0]  screen_row,
  input  logic [sctc_pkg::FIELD_W-1:0]  screen_col,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sctc_pkg::CHAR_W-1:0]   cell_value,
  output logic [sctc_pkg::FIELD_W-1:0]  cursor_row,
  output logic [sctc_pkg::FIELD_W-1:0]  cursor_col,
  output logic [sctc_pkg::FIELD_W-1:0]  top_row
);
  import sctc_pkg::*;

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);

  sctc_mem_ctl_t     mem_ctl;
  logic [AW-1:0]     mem_addr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [CHAR_W-1:0] mem_rdata;

  sctc_ctrl #(
    .ROWS (ROWS),
    .COLS (COLS),
    .AW   (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .char_code  (char_code),
    .screen_row (screen_row),
    .screen_col (screen_col),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cell_value (cell_value),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .top_row    (top_row),
    .mem_ctl    (mem_ctl),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata)
  );

  sctc_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule
